FILE: sv/qdwc_pkg.sv
`timescale 1ns / 1ps

package qdwc_pkg;

  // Step event codes, as carried on the result word.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_CW   = 2'd1;
  localparam logic [1:0] EV_CCW  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HALF_STEP = 2'd0;
  localparam logic [1:0] CFG_MINIMUM   = 2'd1;
  localparam logic [1:0] CFG_MAXIMUM   = 2'd2;
  localparam logic [1:0] CFG_START     = 2'd3;

  localparam int PHASE_W = 3;
  localparam int CODE_W  = 2;

  // One table entry: the next phase and the event it reports.
  typedef struct packed {
    logic [1:0]         ev;
    logic [PHASE_W-1:0] phase;
  } tab_entry_t;

  // Full-step table: a step is reported only on the arrival at code 11.
  function automatic tab_entry_t full_step(input logic [PHASE_W-1:0] row,
                                           input logic [CODE_W-1:0]  code);
    tab_entry_t e;
    e = '{ev: EV_NONE, phase: 3'd0};
    case ({row, code})
      5'b000_01: e.phase = 3'd2;
      5'b000_10: e.phase = 3'd4;
      5'b001_00: e.phase = 3'd3;
      5'b001_10: e.phase = 3'd1;
      5'b001_11: e.ev    = EV_CW;
      5'b010_00: e.phase = 3'd3;
      5'b010_01: e.phase = 3'd2;
      5'b011_00: e.phase = 3'd3;
      5'b011_01: e.phase = 3'd2;
      5'b011_10: e.phase = 3'd1;
      5'b100_00: e.phase = 3'd6;
      5'b100_10: e.phase = 3'd4;
      5'b101_00: e.phase = 3'd6;
      5'b101_01: e.phase = 3'd5;
      5'b101_11: e.ev    = EV_CCW;
      5'b110_00: e.phase = 3'd6;
      5'b110_01: e.phase = 3'd5;
      5'b110_10: e.phase = 3'd4;
      default:   e = '{ev: EV_NONE, phase: 3'd0};
    endcase
    return e;
  endfunction

  // Half-step table: steps are reported at both code 00 and code 11.
  function automatic tab_entry_t half_row_lookup(input logic [PHASE_W-1:0] row,
                                                 input logic [CODE_W-1:0]  code);
    tab_entry_t e;
    e = '{ev: EV_NONE, phase: 3'd0};
    case ({row, code})
      5'b000_00: e.phase = 3'd3;
      5'b000_01: e.phase = 3'd2;
      5'b000_10: e.phase = 3'd1;
      5'b001_00: e = '{ev: EV_CCW, phase: 3'd3};
      5'b001_10: e.phase = 3'd1;
      5'b010_00: e = '{ev: EV_CW, phase: 3'd3};
      5'b010_01: e.phase = 3'd2;
      5'b011_00: e.phase = 3'd3;
      5'b011_01: e.phase = 3'd5;
      5'b011_10: e.phase = 3'd4;
      5'b100_00: e.phase = 3'd3;
      5'b100_01: e.phase = 3'd3;
      5'b100_10: e.phase = 3'd4;
      5'b100_11: e.ev    = EV_CW;
      5'b101_00: e.phase = 3'd3;
      5'b101_01: e.phase = 3'd5;
      5'b101_10: e.phase = 3'd3;
      5'b101_11: e.ev    = EV_CCW;
      default:   e = '{ev: EV_NONE, phase: 3'd0};
    endcase
    return e;
  endfunction

endpackage

FILE: sv/qdwc_phase.sv
`timescale 1ns / 1ps

module qdwc_phase (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     advance,
  input  logic                     half_mode,
  input  logic [qdwc_pkg::CODE_W-1:0] code,
  output logic [1:0]               step_ev
);
  import qdwc_pkg::*;

  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  tab_entry_t         entry;

  // The current phase is used as a row of whichever table is selected now.
  always_comb begin
    entry     = half_mode ? half_row_lookup(phase_r, code) : full_step(phase_r, code);
    step_ev   = entry.ev;
    phase_nxt = advance ? entry.phase : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: sv/quadrature_decoder_wrap_counter_top.sv
`timescale 1ns / 1ps

// Quadrature decoder with a wrapping signed position counter.
// A word accepted into the input register reaches the output via the result register.
// Throughput: one word per cycle; the input register and the result register
// each advance whenever the stage after them is empty or being drained.
// Reset (synchronous, active low) clears the phase, counter, mode and limits.
module quadrature_decoder_wrap_counter_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_pin_a_level,
  input  logic                          in_pin_b_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COUNT_WIDTH-1:0] out_position,
  output logic [1:0]                    out_step_event,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [COUNT_WIDTH-1:0]        cfg_data
);
  import qdwc_pkg::*;

  // Configuration state.
  logic                          half_mode_r;
  logic signed [COUNT_WIDTH-1:0] min_r;
  logic signed [COUNT_WIDTH-1:0] max_r;

  // Input register.
  logic                  s1_valid_r;
  logic [CODE_W-1:0]     s1_code_r;

  // Position counter.
  logic signed [COUNT_WIDTH-1:0] count_r;
  logic signed [COUNT_WIDTH-1:0] count_nxt;

  // Result register.
  logic                          out_valid_r;
  logic signed [COUNT_WIDTH-1:0] out_position_r;
  logic [1:0]                    out_event_r;

  logic                          out_free;
  logic                          s1_adv;
  logic                          cfg_wr;
  logic [1:0]                    step_ev;
  logic signed [COUNT_WIDTH:0]   count_ext;
  logic signed [COUNT_WIDTH:0]   min_ext;
  logic signed [COUNT_WIDTH:0]   max_ext;
  logic signed [COUNT_WIDTH:0]   stepped;
  logic signed [COUNT_WIDTH:0]   wrapped;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;

  assign out_valid      = out_valid_r;
  assign out_position   = out_position_r;
  assign out_step_event = out_event_r;

  qdwc_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s1_adv),
    .half_mode (half_mode_r),
    .code      (s1_code_r),
    .step_ev   (step_ev)
  );

  // Step and wrap, one bit wider than the counter so nothing overflows.
  always_comb begin
    count_ext = {count_r[COUNT_WIDTH-1], count_r};
    min_ext   = {min_r[COUNT_WIDTH-1], min_r};
    max_ext   = {max_r[COUNT_WIDTH-1], max_r};
    stepped   = (step_ev == EV_CW) ? count_ext + (COUNT_WIDTH+1)'(1)
                                   : count_ext - (COUNT_WIDTH+1)'(1);
    if (stepped > max_ext) begin
      wrapped = min_ext;
    end else if (stepped < min_ext) begin
      wrapped = max_ext;
    end else begin
      wrapped = stepped;
    end
    count_nxt = count_r;
    if (cfg_wr && cfg_index == CFG_START) begin
      count_nxt = cfg_data;
    end else if (s1_adv && step_ev != EV_NONE) begin
      count_nxt = wrapped[COUNT_WIDTH-1:0];
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_mode_r <= 1'b0;
      min_r       <= '0;
      max_r       <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_wr) begin
        case (cfg_index)
          CFG_HALF_STEP: half_mode_r <= cfg_data[0];
          CFG_MINIMUM:   min_r       <= cfg_data;
          CFG_MAXIMUM:   max_r       <= cfg_data;
          default:       ;
        endcase
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers; active-high code is {B, A}.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_code_r <= {~in_pin_b_level, ~in_pin_a_level};
    end
    if (s1_adv) begin
      out_position_r <= count_nxt;
      out_event_r    <= step_ev;
    end
  end

endmodule
